[hw/rtl/ffar_pkg.sv]
package ffar_pkg;

  // Frame geometry.
  localparam int FRAME_LEN = 8;
  localparam int POS_W     = 6;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);
  localparam logic [POS_W-1:0] ADDR_POS = POS_W'(2);
  localparam logic [POS_W-1:0] CMD_POS  = POS_W'(3);

  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 16;

  // Configuration register map.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = BYTE_W;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = CFG_IDX_W'(2);

  localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'hFE;
  localparam logic [BYTE_W-1:0] END_BYTE_RST    = 8'hFF;
  localparam logic [BYTE_W-1:0] OWN_ADDRESS_RST = 8'h00;

  typedef enum logic [1:0] {
    STATUS_NONE   = 2'd0,
    STATUS_ACCEPT = 2'd1,
    STATUS_REJECT = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE    = 1'b0,
    ST_COLLECT = 1'b1
  } state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] end_byte;
    logic [BYTE_W-1:0] own_address;
  } cfg_t;

  typedef struct packed {
    status_t            frame_status;
    logic [BYTE_W-1:0]  command_code;
    logic [COUNT_W-1:0] accepted_count;
  } result_t;

endpackage

[hw/rtl/ffar_in_if.sv]
interface ffar_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_data;

  modport source (output valid, output rx_data, input ready);
  modport sink (input valid, input rx_data, output ready);
endinterface

[hw/rtl/ffar_out_if.sv]
interface ffar_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [7:0]  command_code;
  logic [15:0] accepted_count;

  modport source (output valid, output frame_status, output command_code,
                  output accepted_count, input ready);
  modport sink (input valid, input frame_status, input command_code,
                input accepted_count, output ready);
endinterface

[hw/rtl/ffar_cfg_regs.sv]
module ffar_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ffar_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffar_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output ffar_pkg::cfg_t                  cfg
);
  import ffar_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte  <= START_BYTE_RST;
      cfg_r.end_byte    <= END_BYTE_RST;
      cfg_r.own_address <= OWN_ADDRESS_RST;
    end else if (cfg_we) begin
      // Writes to an index beyond the register map are dropped.
      unique case (cfg_index)
        CFG_START_BYTE:  cfg_r.start_byte  <= cfg_wdata;
        CFG_END_BYTE:    cfg_r.end_byte    <= cfg_wdata;
        CFG_OWN_ADDRESS: cfg_r.own_address <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;
endmodule

[hw/rtl/ffar_frame_fsm.sv]
module ffar_frame_fsm (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [ffar_pkg::BYTE_W-1:0] rx_byte,
  input  ffar_pkg::cfg_t              cfg,
  output ffar_pkg::result_t           result
);
  import ffar_pkg::*;

  state_t              state_r, state_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [BYTE_W-1:0]   addr_r, addr_nxt;
  logic [BYTE_W-1:0]   cmd_r, cmd_nxt;
  logic [BYTE_W-1:0]   last_cmd_r, last_cmd_nxt;
  logic [COUNT_W-1:0]  total_r, total_nxt;
  status_t             status;
  logic                frame_ok;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    if (accept) begin
      unique case (state_r)
        ST_IDLE:    if (rx_byte == cfg.start_byte) state_nxt = ST_COLLECT;
        ST_COLLECT: if (pos_r == LAST_POS) state_nxt = ST_IDLE;
        default:    state_nxt = ST_IDLE;
      endcase
    end
  end

  // Frame datapath and status. The address byte is always captured before
  // the last position, so the check can use the stored copy.
  assign frame_ok = (rx_byte == cfg.end_byte) && (addr_r == cfg.own_address);

  always_comb begin
    pos_nxt      = pos_r;
    addr_nxt     = addr_r;
    cmd_nxt      = cmd_r;
    last_cmd_nxt = last_cmd_r;
    total_nxt    = total_r;
    status       = STATUS_NONE;
    if (accept) begin
      unique case (state_r)
        ST_IDLE: begin
          if (rx_byte == cfg.start_byte) pos_nxt = POS_W'(1);
        end
        ST_COLLECT: begin
          if (pos_r == ADDR_POS) addr_nxt = rx_byte;
          if (pos_r == CMD_POS) cmd_nxt = rx_byte;
          if (pos_r == LAST_POS) begin
            pos_nxt = '0;
            if (frame_ok) begin
              last_cmd_nxt = cmd_r;
              total_nxt    = total_r + COUNT_W'(1);
              status       = STATUS_ACCEPT;
            end else begin
              status = STATUS_REJECT;
            end
          end else begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pos_r      <= '0;
      addr_r     <= '0;
      cmd_r      <= '0;
      last_cmd_r <= '0;
      total_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      pos_r      <= pos_nxt;
      addr_r     <= addr_nxt;
      cmd_r      <= cmd_nxt;
      last_cmd_r <= last_cmd_nxt;
      total_r    <= total_nxt;
    end
  end

  assign result.frame_status   = status;
  assign result.command_code   = last_cmd_nxt;
  assign result.accepted_count = total_nxt;
endmodule

[hw/rtl/ffar_out_stage.sv]
module ffar_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  ffar_pkg::result_t result,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              can_load,
  output ffar_pkg::result_t out_result
);
  import ffar_pkg::*;

  logic    valid_r;
  result_t data_r;

  // The register can take a new result when empty or being drained.
  assign can_load = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = data_r;
endmodule

[hw/rtl/fixed_frame_address_receiver_unit.sv]
// Fixed-length frame receiver with address match.
// Received serial bytes arrive one per transfer on the in_ch channel. While
// idle the block waits for the configured start byte; it then collects a
// frame of FRAME_LEN bytes and, at the last position, accepts the frame if
// that byte equals the end byte and frame byte 2 equals the own address.
// Every input transfer produces exactly one result transfer on out_ch,
// carrying the frame status, the command of the last accepted frame and
// the wrapping 16-bit count of accepted frames.
// The cfg_ port writes the start byte, end byte and own address registers
// (indexes 0, 1 and 2) and should only be used while the block is idle.
// A byte taken at an edge has its result on out_ch from the next cycle.
// Throughput is one byte per cycle while out_ch.ready is high, set by
// the single result register, refillable in the same cycle it is drained.
// Reset (rst_n low, synchronous) returns the registers to 0xFE, 0xFF and
// 0x00, clears the frame state and counter, and empties the result register.
// When the receiver holds out_ch.ready low, the pending result is kept and
// in_ch.ready drops, so no further bytes are taken until it is transferred.
module fixed_frame_address_receiver_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  ffar_in_if.sink                         in_ch,
  ffar_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [ffar_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffar_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ffar_pkg::*;

  cfg_t    cfg;
  result_t result;
  result_t out_result;
  logic    can_load;
  logic    in_accept;

  // An input transfer completes whenever the result register has room.
  assign in_ch.ready = can_load;
  assign in_accept   = in_ch.valid && can_load;

  ffar_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ffar_frame_fsm u_frame_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .rx_byte (in_ch.rx_data),
    .cfg     (cfg),
    .result  (result)
  );

  ffar_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_accept),
    .result     (result),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .can_load   (can_load),
    .out_result (out_result)
  );

  assign out_ch.frame_status   = out_result.frame_status;
  assign out_ch.command_code   = out_result.command_code;
  assign out_ch.accepted_count = out_result.accepted_count;
endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import ffar_pkg::*;

  // An index past the end of the register map; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_IDX_W'(3);

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ffar_in_if  in_ch ();
  ffar_out_if out_ch ();

  fixed_frame_address_receiver_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Bytes waiting to be offered on the input channel, filled by the stimulus
  // process and drained by the driver.
  logic [BYTE_W-1:0] pending_bytes[$];

  // One expected result per byte transfer, oldest first.
  result_t expected_results[$];

  // Idle percentages for the sender and the receiver.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // The driver only starts once reset has been released.
  bit drive_enable;

  // Set at a rising edge where the input transfer completed, so that the
  // driver knows at the following falling edge that it may move on.
  bit byte_taken;

  int error_count;

  // Shadow copy of the configuration registers.
  logic [BYTE_W-1:0] cfg_start = START_BYTE_RST;
  logic [BYTE_W-1:0] cfg_end   = END_BYTE_RST;
  logic [BYTE_W-1:0] cfg_addr  = OWN_ADDRESS_RST;

  // Shadow copy of the frame receiver state.
  state_t             rx_state    = ST_IDLE;
  logic [POS_W-1:0]   rx_pos      = '0;
  logic [BYTE_W-1:0]  rx_addr     = '0;
  logic [BYTE_W-1:0]  rx_cmd      = '0;
  logic [BYTE_W-1:0]  last_cmd    = '0;
  logic [COUNT_W-1:0] accept_total = '0;

  // Advances the shadow receiver by one byte and returns the result that
  // the block should report for it.
  function automatic result_t track_frame_byte(input logic [BYTE_W-1:0] rx);
    result_t res;
    res.frame_status = STATUS_NONE;
    if (rx_state == ST_IDLE) begin
      // Anything other than the start byte is simply ignored while idle.
      if (rx == cfg_start) begin
        rx_state = ST_COLLECT;
        rx_pos   = POS_W'(1);
      end
    end else begin
      // A start byte seen here is ordinary frame data: there is no resync.
      if (rx_pos == ADDR_POS) begin
        rx_addr = rx;
      end else if (rx_pos == CMD_POS) begin
        rx_cmd = rx;
      end
      if (rx_pos >= LAST_POS) begin
        if (rx == cfg_end && rx_addr == cfg_addr) begin
          last_cmd     = rx_cmd;
          accept_total = accept_total + COUNT_W'(1);
          res.frame_status = STATUS_ACCEPT;
        end else begin
          // A rejected frame leaves the command and the count untouched.
          res.frame_status = STATUS_REJECT;
        end
        rx_state = ST_IDLE;
        rx_pos   = '0;
      end else begin
        rx_pos = rx_pos + POS_W'(1);
      end
    end
    res.command_code   = last_cmd;
    res.accepted_count = accept_total;
    return res;
  endfunction

  // Clock generation; every input of the block is given a known value at
  // time zero.
  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.rx_data = '0;
    out_ch.ready  = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver. Inputs change only at the falling edge. A byte on offer is held
  // until its transfer completes; the next one may follow straight away, or
  // after a random idle gap. Each signal gets a single
  // nonblocking assignment per edge.
  always @(negedge clk) begin
    if (drive_enable) begin
      if (!in_ch.valid || byte_taken) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.rx_data <= pending_bytes.pop_front();
          in_ch.valid   <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor. Everything is sampled at the rising edge. Register writes and
  // input transfers update the shadow model; output transfers are checked
  // against the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    byte_taken = 1'b0;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_BYTE:  cfg_start = cfg_wdata;
          CFG_END_BYTE:    cfg_end   = cfg_wdata;
          CFG_OWN_ADDRESS: cfg_addr  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        byte_taken = 1'b1;
        expected_results.push_back(track_frame_byte(in_ch.rx_data));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transfer: status %0d command %0d count %0d",
                   $time, out_ch.frame_status, out_ch.command_code, out_ch.accepted_count);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.frame_status !== want.frame_status) begin
            $display("%0t: frame_status expected %0d actual %0d",
                     $time, want.frame_status, out_ch.frame_status);
            error_count++;
          end
          if (out_ch.command_code !== want.command_code) begin
            $display("%0t: command_code expected %0d actual %0d",
                     $time, want.command_code, out_ch.command_code);
            error_count++;
          end
          if (out_ch.accepted_count !== want.accepted_count) begin
            $display("%0t: accepted_count expected %0d actual %0d",
                     $time, want.accepted_count, out_ch.accepted_count);
            error_count++;
          end
        end
      end
    end
  end

  // Writes one register; the write enable is high for exactly one edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued byte has been transferred and every result
  // has come back, plus a short margin.
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_bytes.size() != 0 || in_ch.valid || expected_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  // A byte that the idle receiver will ignore.
  task automatic push_noise();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(255));
    if (b == cfg_start) begin
      b = ~b;
    end
    pending_bytes.push_back(b);
  endtask

  // Queues one frame built from the current configuration. Most frames are
  // well formed; some carry a wrong address or a wrong end byte, and a few
  // are cut short so that the next frame's bytes land in odd positions.
  task automatic push_frame(output int n_bytes);
    int kind;
    int len;
    logic [BYTE_W-1:0] b;
    kind = $urandom_range(99);
    len  = (kind >= 95) ? $urandom_range(1, FRAME_LEN - 1) : FRAME_LEN;
    for (int p = 0; p < len; p++) begin
      if (p == 0) begin
        b = cfg_start;
      end else if (p == ADDR_POS) begin
        b = (kind >= 65 && kind < 80) ? cfg_addr ^ BYTE_W'($urandom_range(1, 255)) : cfg_addr;
      end else if (p == LAST_POS) begin
        b = (kind >= 80 && kind < 95) ? cfg_end ^ BYTE_W'($urandom_range(1, 255)) : cfg_end;
      end else begin
        b = BYTE_W'($urandom_range(255));
      end
      pending_bytes.push_back(b);
    end
    n_bytes = len;
  endtask

  // Random frames with occasional noise between them, until the given
  // number of frame bytes has been queued.
  task automatic run_random_phase(input int target);
    int done;
    int n;
    done = 0;
    while (done < target) begin
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 3)) push_noise();
      end
      push_frame(n);
      done += n;
      while (pending_bytes.size() > 64) @(negedge clk);
    end
    wait_idle();
  endtask

  // Stimulus sequence.
  initial begin
    error_count   = 0;
    drive_enable  = 1'b0;
    send_idle_pct = 30;
    recv_idle_pct = 76;

    // Reset is held at the start and never asserted again.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    drive_enable = 1'b1;

    // Directed part, with the registers at their reset values. Bytes other
    // than the start byte are ignored while idle.
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    // A good frame, with the start byte reappearing as plain data.
    pending_bytes.push_back(START_BYTE_RST);
    pending_bytes.push_back(8'h12);
    pending_bytes.push_back(OWN_ADDRESS_RST);
    pending_bytes.push_back(8'hA5);
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(START_BYTE_RST);
    pending_bytes.push_back(8'h80);
    pending_bytes.push_back(END_BYTE_RST);
    // Right address but wrong end byte: rejected, count unchanged.
    pending_bytes.push_back(START_BYTE_RST);
    pending_bytes.push_back(8'h01);
    pending_bytes.push_back(OWN_ADDRESS_RST);
    pending_bytes.push_back(8'h3C);
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'h7F);
    // Right end byte but wrong address: rejected as well.
    pending_bytes.push_back(START_BYTE_RST);
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(OWN_ADDRESS_RST ^ 8'h01);
    pending_bytes.push_back(8'h5A);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(END_BYTE_RST);
    wait_idle();

    // First random phase: slow sender, heavily stalled receiver. The write
    // to the unmapped index comes last so that a stray effect would show.
    write_reg(CFG_START_BYTE, 8'h00);
    write_reg(CFG_END_BYTE, 8'hFF);
    write_reg(CFG_OWN_ADDRESS, 8'hFF);
    write_reg(CFG_UNMAPPED, 8'h5A);
    run_random_phase(430);

    // Second phase: the idle figures swap round, registers at the opposite
    // extremes.
    send_idle_pct = 76;
    recv_idle_pct = 30;
    write_reg(CFG_START_BYTE, 8'hFF);
    write_reg(CFG_END_BYTE, 8'h00);
    write_reg(CFG_OWN_ADDRESS, 8'h00);
    run_random_phase(430);

    // Third phase: full rate on both sides, random register values.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_START_BYTE, BYTE_W'($urandom_range(255)));
    write_reg(CFG_END_BYTE, BYTE_W'($urandom_range(255)));
    write_reg(CFG_OWN_ADDRESS, BYTE_W'($urandom_range(255)));
    run_random_phase(430);

    repeat (4) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (expected_results.size() != 0) begin
        $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      end
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run.
  initial begin
    #(20_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
